// File: sv/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at each clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dsc_pkg.sv
// ----------------------------------------------------------------------------
// Domain suffix classifier package
// Shared constants, codes and helper functions.
// ----------------------------------------------------------------------------
package dsc_pkg;
    localparam int NAME_BYTES_DEF   = 64;
    localparam int ENTRY_SLOTS_DEF  = 1024;
    localparam int BUCKET_COUNT_DEF = 256;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam int          HASH_SHIFT = 5;
    localparam logic [7:0]  DOT_CHAR  = 8'h2E;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_RSVD   = 2'd3;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  name_byte;
        logic        last_byte;
        logic [15:0] group_tag;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] match_group;
    } t_out_item;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] c);
        return (h << HASH_SHIFT) + h + {24'd0, c};
    endfunction
endpackage

// File: sv/dsc_if.sv
// ----------------------------------------------------------------------------
// Domain suffix classifier stream interfaces
// Valid/ready channels for input and result transactions.
// ----------------------------------------------------------------------------
interface dsc_in_if;
    logic               valid;
    logic               ready;
    dsc_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dsc_out_if;
    logic               valid;
    logic               ready;
    dsc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/dsc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module dsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/domain_suffix_classifier.sv
// A byte that ends no name is taken and the block stays idle; a clear answers after
// a sweep over the bucket heads. An insert copies and hashes the name, then reads and
// updates its bucket head before it answers; a lookup hashes each suffix, walks its
// bucket chain comparing lengths and then bytes, and on a miss scans for the next dot.
// One transaction is in work at a time; input is not ready until its result leaves.
// Reset is synchronous and active low; a sweep over the bucket heads follows it.
// ----------------------------------------------------------------------------
// Domain suffix classifier
// Collects names byte by byte and inserts or suffix-matches them in a hash table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module domain_suffix_classifier #(
    parameter int NAME_BYTES   = dsc_pkg::NAME_BYTES_DEF,
    parameter int ENTRY_SLOTS  = dsc_pkg::ENTRY_SLOTS_DEF,
    parameter int BUCKET_COUNT = dsc_pkg::BUCKET_COUNT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsc_in_if.sink    i_in,
    dsc_out_if.source o_out
);
    import dsc_pkg::*;

    localparam int NW = $clog2(NAME_BYTES);
    localparam int LW = $clog2(NAME_BYTES + 1);
    localparam int SW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
    localparam int TW = $clog2(ENTRY_SLOTS + 1);
    localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int EW = SW + NW;

    typedef enum logic [12:0] {
        S_CLEAR  = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_INS    = 13'b0000000000100,
        S_HRD    = 13'b0000000001000,
        S_HASH   = 13'b0000000010000,
        S_HEAD   = 13'b0000000100000,
        S_HEADW  = 13'b0000001000000,
        S_META   = 13'b0000010000000,
        S_METAW  = 13'b0000100000000,
        S_CMP    = 13'b0001000000000,
        S_CMPW   = 13'b0010000000000,
        S_DOT    = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic [LW-1:0]  r_len;
    logic           r_long;
    logic           r_ins;
    logic [15:0]    r_group;
    logic [LW-1:0]  r_off, r_slen, r_i;
    logic [31:0]    r_hash;
    logic [TW-1:0]  r_total;
    logic [SW:0]    r_link;
    logic [BW-1:0]  r_bkt;
    logic [TW-1:0]  r_steps;
    t_out_item      r_out;
    logic           r_out_v;

    // Name buffer RAM.
    logic          nb_we;
    logic [NW-1:0] nb_waddr, nb_raddr;
    logic [7:0]    nb_wdata, nb_rdata;
    // Entry byte RAM.
    logic          eb_we;
    logic [EW-1:0] eb_waddr, eb_raddr;
    logic [7:0]    eb_rdata;
    // Entry metadata RAM: length, group, link.
    localparam int MW = LW + 16 + SW + 1;
    logic          em_we;
    logic [MW-1:0] em_wdata, em_rdata;
    // Bucket head RAM.
    logic          bh_we;
    logic [BW-1:0] bh_waddr, bh_raddr;
    logic [SW:0]   bh_wdata, bh_rdata;

    dsc_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_name (
        .i_clk, .i_we(nb_we), .i_waddr(nb_waddr), .i_wdata(nb_wdata),
        .i_raddr(nb_raddr), .o_rdata(nb_rdata));
    dsc_ram #(.WIDTH(8), .DEPTH(ENTRY_SLOTS * NAME_BYTES)) u_ebytes (
        .i_clk, .i_we(eb_we), .i_waddr(eb_waddr), .i_wdata(nb_rdata),
        .i_raddr(eb_raddr), .o_rdata(eb_rdata));
    dsc_ram #(.WIDTH(MW), .DEPTH(ENTRY_SLOTS)) u_emeta (
        .i_clk, .i_we(em_we), .i_waddr(r_total[SW-1:0]), .i_wdata(em_wdata),
        .i_raddr(r_link[SW-1:0] - 1'b1), .o_rdata(em_rdata));
    dsc_ram #(.WIDTH(SW + 1), .DEPTH(BUCKET_COUNT)) u_bhead (
        .i_clk, .i_we(bh_we), .i_waddr(bh_waddr), .i_wdata(bh_wdata),
        .i_raddr(bh_raddr), .o_rdata(bh_rdata));

    logic [LW-1:0] m_len;
    logic [15:0]   m_grp;
    logic [SW:0]   m_link;
    assign {m_len, m_grp, m_link} = em_rdata;

    logic in_fire, out_fire, bad;
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_fire = o_out.valid && o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && !r_out_v;
    assign o_out.valid = r_out_v;
    assign o_out.data  = r_out;
    assign bad = r_long || (r_len == '0);

    logic          store_byte;
    logic [LW-1:0] pos;
    assign store_byte = in_fire && (i_in.data.mode != MODE_RSVD)
                        && (i_in.data.mode != MODE_CLEAR)
                        && !r_long && (r_len < LW'(NAME_BYTES - 1));
    assign pos = r_off + r_i;

    always_comb begin
        nb_we    = store_byte;
        nb_waddr = r_len[NW-1:0];
        nb_wdata = to_lower(i_in.data.name_byte);
        nb_raddr = pos[NW-1:0];
        eb_we    = 1'b0;
        eb_waddr = {r_total[SW-1:0], NW'(r_i - 1'b1)};
        eb_raddr = {r_link[SW-1:0] - 1'b1, r_i[NW-1:0]};
        em_we    = 1'b0;
        em_wdata = {r_len, r_group, bh_rdata};
        bh_we    = 1'b0;
        bh_waddr = r_bkt;
        bh_wdata = '0;
        bh_raddr = BW'(r_hash % BUCKET_COUNT);
        case (r_state)
            S_CLEAR: begin
                bh_we = 1'b1;
            end
            S_INS: begin
                eb_we = (r_i != '0);
            end
            S_HEADW: begin
                if (r_ins) begin
                    em_we    = 1'b1;
                    bh_we    = 1'b1;
                    bh_waddr = BW'(r_hash % BUCKET_COUNT);
                    bh_wdata = (SW + 1)'(r_total + 1'b1);
                end
            end
            default: begin
            end
        endcase
    end

    logic [TW-1:0] n_total;
    logic [SW:0]   n_link;
    logic [LW-1:0] n_len, n_off, n_slen, n_i;
    logic [31:0]   n_hash;
    logic [BW-1:0] n_bkt;
    logic [TW-1:0] n_steps;
    logic          n_long, n_out_v, n_ins;
    t_out_item     n_out;

    always_comb begin
        n_state = r_state;
        n_total = r_total;
        n_link  = r_link;
        n_len   = r_len;
        n_long  = r_long;
        n_off   = r_off;
        n_slen  = r_slen;
        n_i     = r_i;
        n_hash  = r_hash;
        n_bkt   = r_bkt;
        n_steps = r_steps;
        n_ins   = r_ins;
        n_out   = r_out;
        n_out_v = r_out_v && !out_fire;
        case (r_state)
            S_CLEAR: begin
                n_bkt = r_bkt + 1'b1;
                if (r_bkt == BW'(BUCKET_COUNT - 1)) begin
                    n_state = S_IDLE;
                    if (r_ins) begin
                        n_out_v = 1'b1;
                        n_out   = '{kind: KIND_CLEAR, status: ST_OK, match_group: 16'd0};
                    end
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.data.mode == MODE_CLEAR) begin
                        n_total = '0;
                        n_len   = '0;
                        n_long  = 1'b0;
                        n_bkt   = '0;
                        n_ins   = 1'b1;
                        n_state = S_CLEAR;
                    end else if (i_in.data.mode != MODE_RSVD) begin
                        if (store_byte) begin
                            n_len = r_len + 1'b1;
                        end else if (!r_long) begin
                            n_long = 1'b1;
                        end
                        if (i_in.data.last_byte) begin
                            n_ins  = (i_in.data.mode == MODE_INSERT);
                            n_off  = '0;
                            n_i    = '0;
                            n_hash = HASH_SEED;
                            n_state = S_OUT;
                            if (i_in.data.mode == MODE_INSERT) begin
                                n_out = '{kind: KIND_INSERT, status: ST_OK,
                                          match_group: 16'd0};
                            end else begin
                                n_out = '{kind: KIND_LOOKUP, status: ST_OK,
                                          match_group: 16'd0};
                            end
                        end
                    end
                end
            end
            S_OUT: begin
                // First step after a name end: decide between result and work.
                n_slen = r_len;
                if (bad) begin
                    if (r_ins) n_out.status = ST_BAD_LEN;
                    n_state = S_DOT; n_slen = '0;
                end else if (r_ins && r_total >= TW'(ENTRY_SLOTS)) begin
                    n_out.status = ST_FULL;
                    n_state = S_DOT; n_slen = '0;
                end else begin
                    n_state = r_ins ? S_INS : S_HRD;
                end
            end
            S_INS: begin
                // Copy byte r_i-1 (read last cycle) while hashing it.
                if (r_i != '0) n_hash = hash_step(r_hash, nb_rdata);
                n_i = r_i + 1'b1;
                if (r_i == r_len) n_state = S_HEAD;
            end
            S_HRD: begin
                n_state = S_HASH;
            end
            S_HASH: begin
                n_hash = hash_step(r_hash, nb_rdata);
                n_i    = r_i + 1'b1;
                n_state = (r_i + 1'b1 == r_slen) ? S_HEAD : S_HRD;
            end
            S_HEAD: begin
                n_state = S_HEADW;
            end
            S_HEADW: begin
                if (r_ins) begin
                    n_total = r_total + 1'b1;
                    n_len   = '0;
                    n_long  = 1'b0;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_link  = bh_rdata;
                    n_steps = '0;
                    n_state = S_META;
                end
            end
            S_META: begin
                if (r_link == '0 || r_steps >= TW'(ENTRY_SLOTS)) begin
                    n_i = '0;
                    n_state = S_DOT;
                end else begin
                    n_state = S_METAW;
                end
            end
            S_METAW: begin
                n_i = '0;
                n_state = (m_len == r_slen) ? S_CMP : S_META;
                if (m_len != r_slen) begin
                    n_link  = m_link;
                    n_steps = r_steps + 1'b1;
                end
            end
            S_CMP: begin
                n_state = S_CMPW;
            end
            S_CMPW: begin
                if (eb_rdata != nb_rdata) begin
                    n_link  = m_link;
                    n_steps = r_steps + 1'b1;
                    n_state = S_META;
                end else if (r_i + 1'b1 == r_slen) begin
                    n_out.match_group = m_grp;
                    n_slen  = '0;
                    n_state = S_DOT;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = S_CMP;
                end
            end
            S_DOT: begin
                // Scan for the first dot, with a wait step before each byte test; empty suffix ends.
                if (r_slen == '0 || r_i == r_slen) begin
                    n_len   = '0;
                    n_long  = 1'b0;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end else if (r_hash == 32'd0) begin
                    n_hash = 32'd1;
                end else begin
                    n_hash = 32'd0;
                    if (nb_rdata == DOT_CHAR) begin
                        n_off  = r_off + r_i + 1'b1;
                        n_slen = r_slen - r_i - 1'b1;
                        n_i    = '0;
                        n_hash = HASH_SEED;
                        n_state = (r_slen - r_i - 1'b1 == '0) ? S_DOT : S_HRD;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (r_state == S_META && (r_link == '0 || r_steps >= TW'(ENTRY_SLOTS))) begin
            n_hash = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_total <= '0;
            r_len   <= '0;
            r_long  <= 1'b0;
            r_bkt   <= '0;
            r_ins   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_len   <= n_len;
            r_long  <= n_long;
            r_bkt   <= n_bkt;
            r_ins   <= n_ins;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link  <= n_link;
        r_off   <= n_off;
        r_slen  <= n_slen;
        r_i     <= n_i;
        r_hash  <= n_hash;
        r_steps <= n_steps;
        r_group <= (in_fire) ? i_in.data.group_tag : r_group;
        r_out   <= n_out;
    end

    `ASSERT_IMPLIES(a_total_cap, i_clk, i_rst_n, 1'b1, r_total <= TW'(ENTRY_SLOTS),
        "entry count beyond table size")
    `ASSERT_IMPLIES(a_len_cap, i_clk, i_rst_n, 1'b1, r_len < LW'(NAME_BYTES),
        "name length beyond buffer")
    `ASSERT_NEXT(a_busy, i_clk, i_rst_n, in_fire && i_in.data.mode == MODE_CLEAR,
        r_state == S_CLEAR, "clear did not start a sweep")
endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Domain suffix classifier testbench
// Streams insert, lookup and clear transactions into the classifier, predicts
// results with a behavioural copy of the hash table or takes them from the directed
// rows, and checks the results in order, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import dsc_pkg::*;

    localparam int NB = NAME_BYTES_DEF;
    localparam int NE = ENTRY_SLOTS_DEF;
    localparam int NK = BUCKET_COUNT_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        t_in_item  it;
        bit        typed;
        t_out_item want;
    } t_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #6 clk = ~clk;

    dsc_in_if  in_if();
    dsc_out_if out_if();

    domain_suffix_classifier dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Behavioural copy of the classifier state.
    logic [7:0]  cur_name [NB];
    int          cur_len;
    bit          cur_long;
    logic [7:0]  tbl_bytes [NE][NB];
    int          tbl_len [NE];
    logic [15:0] tbl_group [NE];
    int          tbl_link [NE];
    int          tbl_head [NK];
    int          tbl_count;

    t_out_item   pending_results[$];
    bit          failed = 1'b0;
    bit          quiet = 1'b0;
    int          rd_wait = 0;
    longint      cycles = 0;

    // Name staging for the stimulus and a pool of inserted domains.
    logic [7:0]  nbuf [128];
    int          nlen;
    logic [7:0]  pool [32][8];
    int          pool_len [32];

    function automatic int bucket_of(int off, int len);
        logic [31:0] h;
        h = HASH_SEED;
        for (int i = 0; i < len; i++) begin
            h = (h << HASH_SHIFT) + h + {24'd0, cur_name[off + i]};
        end
        return int'(h % NK);
    endfunction

    function automatic logic [1:0] table_insert(logic [15:0] grp);
        int b;
        if (cur_long || cur_len == 0) return ST_BAD_LEN;
        if (tbl_count >= NE) return ST_FULL;
        for (int i = 0; i < cur_len; i++) tbl_bytes[tbl_count][i] = cur_name[i];
        tbl_len[tbl_count] = cur_len;
        tbl_group[tbl_count] = grp;
        b = bucket_of(0, cur_len);
        tbl_link[tbl_count] = tbl_head[b];
        tbl_head[b] = tbl_count + 1;
        tbl_count++;
        return ST_OK;
    endfunction

    function automatic logic [15:0] suffix_lookup();
        int off, len, link, steps, idx, dot;
        bit same;
        off = 0;
        len = cur_len;
        if (cur_long || cur_len == 0) return 16'd0;
        while (len > 0) begin
            link = tbl_head[bucket_of(off, len)];
            steps = 0;
            while (link != 0 && steps < NE) begin
                idx = link - 1;
                if (tbl_len[idx] == len) begin
                    same = 1'b1;
                    for (int i = 0; i < len; i++)
                        if (tbl_bytes[idx][i] != cur_name[off + i]) same = 1'b0;
                    if (same) return tbl_group[idx];
                end
                link = tbl_link[idx];
                steps++;
            end
            dot = len;
            for (int i = 0; i < len; i++) begin
                if (cur_name[off + i] == DOT_CHAR) begin
                    dot = i;
                    break;
                end
            end
            if (dot == len) break;
            off += dot + 1;
            len -= dot + 1;
        end
        return 16'd0;
    endfunction

    // Advances the copy by one accepted transaction; returns 1 when a result is due.
    function automatic bit classify(t_in_item it, output t_out_item r);
        logic [7:0] c;
        r = '0;
        if (it.mode == MODE_RSVD) return 1'b0;
        if (it.mode == MODE_CLEAR) begin
            for (int i = 0; i < NK; i++) tbl_head[i] = 0;
            tbl_count = 0;
            cur_len = 0;
            cur_long = 1'b0;
            r.kind = KIND_CLEAR;
            return 1'b1;
        end
        c = (it.name_byte >= 8'h41 && it.name_byte <= 8'h5A) ? it.name_byte + 8'h20
                                                              : it.name_byte;
        if (!cur_long) begin
            if (cur_len >= NB - 1) cur_long = 1'b1;
            else cur_name[cur_len++] = c;
        end
        if (!it.last_byte) return 1'b0;
        if (it.mode == MODE_INSERT) begin
            r.kind = KIND_INSERT;
            r.status = table_insert(it.group_tag);
        end else begin
            r.kind = KIND_LOOKUP;
            r.match_group = suffix_lookup();
        end
        cur_len = 0;
        cur_long = 1'b0;
        return 1'b1;
    endfunction

    task automatic send(t_in_item it, bit typed = 1'b0, t_out_item want = '0);
        int gap;
        t_out_item r;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do @(posedge clk); while (!in_if.ready);
        if (classify(it, r)) pending_results.push_back(typed ? want : r);
    endtask

    function automatic t_in_item mk(logic [1:0] m, logic [7:0] b, logic l, logic [15:0] g);
        t_in_item it;
        it.mode = m;
        it.name_byte = b;
        it.last_byte = l;
        it.group_tag = g;
        return it;
    endfunction

    function automatic t_row row(t_in_item it, bit typed = 1'b0, t_out_item want = '0);
        t_row r;
        r.it = it;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic logic [7:0] rand_char();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return 8'($urandom_range(0, 255));
        case (k % 5)
            0: return "a";
            1: return "b";
            2: return "A";
            3: return "z";
            default: return "-";
        endcase
    endfunction

    function automatic void add_label();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) nbuf[nlen++] = rand_char();
    endfunction

    task automatic send_name(logic [1:0] m, bit mixed);
        logic [1:0] mm;
        for (int i = 0; i < nlen; i++) begin
            mm = (mixed && i < nlen - 1) ? 2'($urandom_range(0, 1)) : m;
            send(mk(mm, nbuf[i], i == nlen - 1, 16'($urandom_range(0, 65535))));
        end
    endtask

    task automatic random_sequence();
        int k, p;
        k = $urandom_range(0, 99);
        p = $urandom_range(0, 31);
        nlen = 0;
        if (k < 4) begin
            send(mk(MODE_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom)));
        end else if (k < 9) begin
            send(mk(MODE_RSVD, 8'($urandom), 1'($urandom), 16'($urandom)));
        end else if (k < 11) begin
            // Lengths either side of the buffer limit.
            nlen = $urandom_range(NB - 2, NB + 1);
            for (int i = 0; i < nlen; i++) nbuf[i] = rand_char();
            send_name(2'($urandom_range(0, 1)), 1'b0);
        end else if (k < 45) begin
            if ($urandom_range(0, 2) == 0) begin
                pool_len[p] = 0;
                add_label();
                if ($urandom_range(0, 1)) begin
                    nbuf[nlen++] = DOT_CHAR;
                    add_label();
                end
                for (int i = 0; i < nlen; i++) pool[p][i] = nbuf[i];
                pool_len[p] = nlen;
            end else begin
                for (int i = 0; i < pool_len[p]; i++) nbuf[nlen++] = pool[p][i];
            end
            send_name(MODE_INSERT, $urandom_range(0, 9) == 0);
        end else begin
            for (int j = $urandom_range(0, 2); j > 0; j--) begin
                add_label();
                nbuf[nlen++] = DOT_CHAR;
            end
            if ($urandom_range(0, 4) == 0) add_label();
            else for (int i = 0; i < pool_len[p]; i++) nbuf[nlen++] = pool[p][i];
            if ($urandom_range(0, 9) == 0) nbuf[nlen++] = DOT_CHAR;
            send_name(MODE_LOOKUP, $urandom_range(0, 9) == 0);
        end
    endtask

    // Result channel: random stalls, with quiet stretches of none.
    always @(posedge clk) begin
        if (out_if.ready && out_if.valid) begin
            int w;
            w = quiet ? 0 : $urandom_range(0, 6);
            if (w > 0) begin
                out_if.ready <= 1'b0;
                rd_wait <= w;
            end
        end else if (!out_if.ready) begin
            if (rd_wait <= 1) out_if.ready <= 1'b1;
            else rd_wait <= rd_wait - 1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction kind=%0d", out_if.data.kind);
                failed = 1'b1;
            end else begin
                t_out_item e;
                e = pending_results.pop_front();
                if (out_if.data.kind !== e.kind) begin
                    $error("kind: expected %0d, actual %0d", e.kind, out_if.data.kind);
                    failed = 1'b1;
                end
                if (out_if.data.status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, out_if.data.status);
                    failed = 1'b1;
                end
                if (out_if.data.match_group !== e.match_group) begin
                    $error("match_group: expected %0d, actual %0d",
                           e.match_group, out_if.data.match_group);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_row      steps[$];
        t_out_item w;
        int        waited;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        cur_len = 0;
        cur_long = 1'b0;
        tbl_count = 0;
        for (int i = 0; i < NK; i++) tbl_head[i] = 0;
        for (int i = 0; i < 32; i++) begin
            pool[i][0] = "a";
            pool_len[i] = 1;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        w = '0;
        w.kind = KIND_LOOKUP;
        steps.push_back(row(mk(MODE_LOOKUP, "a", 1'b1, 16'h0000), 1'b1, w));
        w.kind = KIND_INSERT;
        steps.push_back(row(mk(MODE_INSERT, "A", 1'b1, 16'hFFFF), 1'b1, w));
        steps.push_back(row(mk(MODE_LOOKUP, "x", 1'b0, 16'h0000)));
        steps.push_back(row(mk(MODE_LOOKUP, DOT_CHAR, 1'b0, 16'h0000)));
        steps.push_back(row(mk(MODE_LOOKUP, "a", 1'b1, 16'h0000)));
        // Mixed modes: the last byte decides the operation.
        steps.push_back(row(mk(MODE_INSERT, 8'hFF, 1'b0, 16'h1234)));
        steps.push_back(row(mk(MODE_LOOKUP, 8'h00, 1'b1, 16'hFFFF)));
        // A trailing dot leaves an empty suffix, which matches nothing.
        w.kind = KIND_LOOKUP;
        steps.push_back(row(mk(MODE_LOOKUP, "a", 1'b0, 16'h0000)));
        steps.push_back(row(mk(MODE_LOOKUP, DOT_CHAR, 1'b1, 16'h0000), 1'b1, w));
        steps.push_back(row(mk(MODE_RSVD, 8'hFF, 1'b1, 16'hFFFF)));
        steps.push_back(row(mk(MODE_INSERT, "Z", 1'b0, 16'h0001)));
        w.kind = KIND_CLEAR;
        steps.push_back(row(mk(MODE_CLEAR, 8'h00, 1'b0, 16'h0000), 1'b1, w));
        w.kind = KIND_LOOKUP;
        steps.push_back(row(mk(MODE_LOOKUP, "a", 1'b1, 16'h0000), 1'b1, w));
        w.kind = KIND_INSERT;
        steps.push_back(row(mk(MODE_INSERT, 8'h00, 1'b1, 16'h0000), 1'b1, w));
        steps.push_back(row(mk(MODE_LOOKUP, 8'h00, 1'b1, 16'h0000)));
        steps.push_back(row(mk(MODE_INSERT, "z", 1'b1, 16'h8001)));
        steps.push_back(row(mk(MODE_LOOKUP, "Z", 1'b1, 16'h0000)));
        foreach (steps[i]) send(steps[i].it, steps[i].typed, steps[i].want);

        // Fill the table to its last slot, then overflow it.
        send(mk(MODE_CLEAR, 8'h00, 1'b1, 16'h0000));
        for (int i = 0; i < NE + 2; i++) begin
            quiet = (i % 300) > 200;
            send(mk(MODE_INSERT, 8'($urandom), 1'b1, 16'($urandom)));
        end
        quiet = 1'b0;
        for (int i = 0; i < 4; i++) send(mk(MODE_LOOKUP, 8'($urandom), 1'b1, 16'h0000));
        send(mk(MODE_CLEAR, 8'h00, 1'b0, 16'h0000));

        for (int i = 0; i < 60; i++) begin
            quiet = (i % 40) >= 32;
            random_sequence();
        end
        quiet = 1'b0;
        in_if.valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0) @(posedge clk);
        while (waited < 2000) begin
            @(posedge clk);
            waited++;
        end
        if (!failed && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// File: filelist.f
+incdir+sv
sv/dsc_pkg.sv
sv/dsc_if.sv
sv/dsc_ram.sv
sv/domain_suffix_classifier.sv
tb/sv/tb_top.sv
